### hw/rtl/mjt_pkg.sv
package mjt_pkg;

    localparam int POS_BITS   = 24;
    localparam int FRAC_BITS  = 24;
    localparam int CNT_BITS   = 16;
    localparam int DELTA_BITS = POS_BITS + 1;
    localparam int TAU_BITS   = FRAC_BITS + 1;
    localparam int MUL_W      = ((DELTA_BITS > TAU_BITS) ? DELTA_BITS : TAU_BITS) + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = FRAC_BITS + 6;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS);

    localparam logic [CNT_BITS-1:0] NUM_POINTS_RST = CNT_BITS'(100);
    localparam logic [TAU_BITS-1:0] ONE_Q          = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TAU,
        ST_MUL,
        ST_WB,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MS_T2,
        MS_T3,
        MS_T4,
        MS_T5,
        MS_PX,
        MS_PY,
        MS_PZ
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_init;
        logic     div_step;
        logic     tau_load;
        logic     mul_go;
        logic     wb;
        logic     sum;
        logic     out_load;
        mul_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/mjt_ctrl.sv
module mjt_ctrl import mjt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_mode,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t                 state_reg, state_next;
    mul_sel_t               sel_reg, sel_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= MS_T2;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        div_cnt_next = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_mode == MODE_TICK) && stat.active) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(FRAC_BITS - 1)) begin
                    state_next = ST_TAU;
                end
            end
            ST_TAU: begin
                state_next = ST_MUL;
                sel_next   = MS_T2;
            end
            ST_MUL: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                case (sel_reg)
                    MS_T5:   state_next = ST_SUM;
                    MS_PZ:   state_next = ST_OUT;
                    default: begin
                        state_next = ST_MUL;
                        sel_next   = mul_sel_t'(sel_reg + 3'd1);
                    end
                endcase
            end
            ST_SUM: begin
                state_next = ST_MUL;
                sel_next   = MS_PX;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cmd          = '0;
        cmd.sel      = sel_reg;
        cmd.load     = (state_reg == ST_IDLE) && s_valid && (s_mode == MODE_LOAD);
        cmd.div_init = (state_reg == ST_IDLE) && s_valid && (s_mode == MODE_TICK)
                       && stat.active;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.tau_load = (state_reg == ST_TAU);
        cmd.mul_go   = (state_reg == ST_MUL);
        cmd.wb       = (state_reg == ST_WB);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.out_load = (state_reg == ST_OUT) && stat.out_free;
    end

endmodule

### hw/rtl/mjt_dp.sv
module mjt_dp import mjt_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic                       cfg_valid,
    input  logic [CNT_BITS-1:0]        cfg_data,
    input  logic signed [POS_BITS-1:0] s_start_x,
    input  logic signed [POS_BITS-1:0] s_start_y,
    input  logic signed [POS_BITS-1:0] s_start_z,
    input  logic signed [POS_BITS-1:0] s_end_x,
    input  logic signed [POS_BITS-1:0] s_end_y,
    input  logic signed [POS_BITS-1:0] s_end_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_BITS-1:0] m_pos_x,
    output logic signed [POS_BITS-1:0] m_pos_y,
    output logic signed [POS_BITS-1:0] m_pos_z,
    output logic [CNT_BITS-1:0]        m_sample_index,
    output logic                       m_last
);

    logic [CNT_BITS-1:0]          num_points_reg;
    logic [CNT_BITS-1:0]          cnt_reg;
    logic                         active_reg;
    logic signed [POS_BITS-1:0]   start_reg [3];
    logic signed [DELTA_BITS-1:0] delta_reg [3];
    logic signed [POS_BITS-1:0]   pos_reg   [3];
    logic [CNT_BITS-1:0]          rem_reg;
    logic [FRAC_BITS-1:0]         quo_reg;
    logic [TAU_BITS-1:0]          tau_reg;
    logic [TAU_BITS-1:0]          pw_reg;
    logic [TAU_BITS-1:0]          t3_reg;
    logic [TAU_BITS-1:0]          t4_reg;
    logic [TAU_BITS-1:0]          t5_reg;
    logic [TAU_BITS-1:0]          s_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         m_valid_reg;
    logic signed [POS_BITS-1:0]   m_pos_x_reg, m_pos_y_reg, m_pos_z_reg;
    logic [CNT_BITS-1:0]          m_idx_reg;
    logic                         m_last_reg;

    logic [CNT_BITS-1:0]          n_w;
    logic                         sat_w;
    logic                         last_w;
    logic [CNT_BITS:0]            rem_sh_w;
    logic [CNT_BITS:0]            rem_sub_w;
    logic                         ge_w;
    logic signed [MUL_W-1:0]      mul_a_w, mul_b_w;
    logic [TAU_BITS-1:0]          pw_new_w;
    logic signed [POS_BITS-1:0]   pos_new_w;
    logic signed [SUM_W-1:0]      e3_w, e4_w, e5_w, s_sum_w;
    logic [TAU_BITS-1:0]          s_clamp_w;

    assign n_w    = (num_points_reg == '0) ? CNT_BITS'(1) : num_points_reg;
    assign sat_w  = (cnt_reg >= n_w);
    assign last_w = (({1'b0, cnt_reg} + (CNT_BITS+1)'(1)) >= {1'b0, n_w});

    // restoring divide of j * 2^FRAC_BITS by n, one quotient bit per step
    assign rem_sh_w  = {rem_reg, 1'b0};
    assign ge_w      = (rem_sh_w >= {1'b0, n_w});
    assign rem_sub_w = rem_sh_w - {1'b0, n_w};

    always_comb begin
        case (cmd.sel)
            MS_T2: begin
                mul_a_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, tau_reg});
                mul_b_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, tau_reg});
            end
            MS_T3, MS_T4, MS_T5: begin
                mul_a_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, pw_reg});
                mul_b_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, tau_reg});
            end
            MS_PX: begin
                mul_a_w = MUL_W'(delta_reg[0]);
                mul_b_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, s_reg});
            end
            MS_PY: begin
                mul_a_w = MUL_W'(delta_reg[1]);
                mul_b_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, s_reg});
            end
            MS_PZ: begin
                mul_a_w = MUL_W'(delta_reg[2]);
                mul_b_w = $signed({{(MUL_W-TAU_BITS){1'b0}}, s_reg});
            end
            default: begin
                mul_a_w = '0;
                mul_b_w = '0;
            end
        endcase
    end

    assign pw_new_w = prod_reg[FRAC_BITS +: TAU_BITS];

    always_comb begin
        case (cmd.sel)
            MS_PX:   pos_new_w = start_reg[0] + prod_reg[FRAC_BITS +: POS_BITS];
            MS_PY:   pos_new_w = start_reg[1] + prod_reg[FRAC_BITS +: POS_BITS];
            MS_PZ:   pos_new_w = start_reg[2] + prod_reg[FRAC_BITS +: POS_BITS];
            default: pos_new_w = '0;
        endcase
    end

    // s = 10 t3 - 15 t4 + 6 t5, clamped to [0, 1.0]
    assign e3_w    = $signed({{(SUM_W-TAU_BITS){1'b0}}, t3_reg});
    assign e4_w    = $signed({{(SUM_W-TAU_BITS){1'b0}}, t4_reg});
    assign e5_w    = $signed({{(SUM_W-TAU_BITS){1'b0}}, t5_reg});
    assign s_sum_w = (e3_w <<< 3) + (e3_w <<< 1) - ((e4_w <<< 4) - e4_w)
                   + (e5_w <<< 2) + (e5_w <<< 1);

    always_comb begin
        if (s_sum_w[SUM_W-1]) begin
            s_clamp_w = '0;
        end else if (s_sum_w > $signed({{(SUM_W-TAU_BITS){1'b0}}, ONE_Q})) begin
            s_clamp_w = ONE_Q;
        end else begin
            s_clamp_w = s_sum_w[TAU_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= NUM_POINTS_RST;
            cnt_reg        <= '0;
            active_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                num_points_reg <= cfg_data;
            end
            if (cmd.load) begin
                cnt_reg    <= '0;
                active_reg <= 1'b1;
            end else if (cmd.out_load) begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (last_w) begin
                    active_reg <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg[0] <= s_start_x;
            start_reg[1] <= s_start_y;
            start_reg[2] <= s_start_z;
            delta_reg[0] <= DELTA_BITS'(s_end_x) - DELTA_BITS'(s_start_x);
            delta_reg[1] <= DELTA_BITS'(s_end_y) - DELTA_BITS'(s_start_y);
            delta_reg[2] <= DELTA_BITS'(s_end_z) - DELTA_BITS'(s_start_z);
        end
        if (cmd.div_init) begin
            rem_reg <= cnt_reg;
        end else if (cmd.div_step) begin
            rem_reg <= ge_w ? rem_sub_w[CNT_BITS-1:0] : rem_sh_w[CNT_BITS-1:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], ge_w};
        end
        if (cmd.tau_load) begin
            tau_reg <= sat_w ? ONE_Q : {1'b0, quo_reg};
        end
        if (cmd.mul_go) begin
            prod_reg <= mul_a_w * mul_b_w;
        end
        if (cmd.wb) begin
            case (cmd.sel)
                MS_T2: pw_reg <= pw_new_w;
                MS_T3: begin
                    pw_reg <= pw_new_w;
                    t3_reg <= pw_new_w;
                end
                MS_T4: begin
                    pw_reg <= pw_new_w;
                    t4_reg <= pw_new_w;
                end
                MS_T5:   t5_reg     <= pw_new_w;
                MS_PX:   pos_reg[0] <= pos_new_w;
                MS_PY:   pos_reg[1] <= pos_new_w;
                MS_PZ:   pos_reg[2] <= pos_new_w;
                default: pw_reg     <= pw_reg;
            endcase
        end
        if (cmd.sum) begin
            s_reg <= s_clamp_w;
        end
        if (cmd.out_load) begin
            m_pos_x_reg <= pos_reg[0];
            m_pos_y_reg <= pos_reg[1];
            m_pos_z_reg <= pos_reg[2];
            m_idx_reg   <= cnt_reg;
            m_last_reg  <= last_w;
        end
    end

    assign stat.active   = active_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_pos_x        = m_pos_x_reg;
    assign m_pos_y        = m_pos_y_reg;
    assign m_pos_z        = m_pos_z_reg;
    assign m_sample_index = m_idx_reg;
    assign m_last         = m_last_reg;

endmodule

### hw/rtl/min_jerk_trajectory_generator.sv
// Three-axis minimum-jerk trajectory generator. A load item (s_mode = 0) stores start and end
// positions and arms a move, giving no result. Each tick item (s_mode = 1) during a move
// yields one sample, j = 0 .. num_points-1, with m_last set on the final one; ticks while
// idle are dropped. From acceptance to the next s_ready, a sample passes the bit-serial tau
// divider (one quotient bit a cycle), tau set-up, the single shared multiplier for t^2..t^5,
// the blend sum, then that multiplier again for the three axis products (each product a
// multiply and a write-back step), and the output load, which waits while the output register is still held.
// num_points (cfg_data) may only be written while no move sample is in progress.
module min_jerk_trajectory_generator import mjt_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CNT_BITS-1:0]        cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic signed [POS_BITS-1:0] s_start_x,
    input  logic signed [POS_BITS-1:0] s_start_y,
    input  logic signed [POS_BITS-1:0] s_start_z,
    input  logic signed [POS_BITS-1:0] s_end_x,
    input  logic signed [POS_BITS-1:0] s_end_y,
    input  logic signed [POS_BITS-1:0] s_end_z,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_BITS-1:0] m_pos_x,
    output logic signed [POS_BITS-1:0] m_pos_y,
    output logic signed [POS_BITS-1:0] m_pos_z,
    output logic [CNT_BITS-1:0]        m_sample_index,
    output logic                       m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mjt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mjt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_start_z      (s_start_z),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .s_end_z        (s_end_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_pos_z        (m_pos_z),
        .m_sample_index (m_sample_index),
        .m_last         (m_last)
    );

endmodule

### sim/trajectory_checker.sv
`timescale 1ns / 100ps

module trajectory_checker import mjt_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CNT_BITS-1:0]        cfg_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_mode,
    input  logic signed [POS_BITS-1:0] s_start_x,
    input  logic signed [POS_BITS-1:0] s_start_y,
    input  logic signed [POS_BITS-1:0] s_start_z,
    input  logic signed [POS_BITS-1:0] s_end_x,
    input  logic signed [POS_BITS-1:0] s_end_y,
    input  logic signed [POS_BITS-1:0] s_end_z,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [POS_BITS-1:0] m_pos_x,
    input  logic signed [POS_BITS-1:0] m_pos_y,
    input  logic signed [POS_BITS-1:0] m_pos_z,
    input  logic [CNT_BITS-1:0]        m_sample_index,
    input  logic                       m_last,
    output int                         mismatches,
    output int                         pending
);

    typedef struct packed {
        logic [POS_BITS-1:0] x;
        logic [POS_BITS-1:0] y;
        logic [POS_BITS-1:0] z;
        logic [CNT_BITS-1:0] index;
        logic                last;
    } sample_t;

    sample_t              expected_samples[$];
    longint               move_origin[3];
    longint               move_span[3];
    logic [CNT_BITS-1:0]  next_index;
    logic [CNT_BITS-1:0]  points_reg;
    logic                 move_live;

    always @(posedge aclk) begin : track_trajectory
        sample_t             got;
        sample_t             want;
        longint unsigned     n;
        longint unsigned     j;
        longint unsigned     tau;
        longint unsigned     p2;
        longint unsigned     p3;
        longint unsigned     p4;
        longint unsigned     p5;
        longint              blend;
        longint              start_v[3];
        longint              end_v[3];
        logic [POS_BITS-1:0] axis_pos[3];
        int                  k;

        if (!aresetn) begin
            expected_samples.delete();
            for (k = 0; k < 3; k++) begin
                move_origin[k] = 0;
                move_span[k]   = 0;
            end
            next_index = '0;
            points_reg = NUM_POINTS_RST;
            move_live  = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                points_reg = cfg_data;
            end

            if (m_valid && m_ready) begin
                got = '{m_pos_x, m_pos_y, m_pos_z, m_sample_index, m_last};
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected item x=%0d y=%0d z=%0d idx=%0d last=%0b",
                                 $time, m_pos_x, m_pos_y, m_pos_z, m_sample_index, m_last);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.index !== want.index || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch, expected x=%0d y=%0d z=%0d idx=%0d last=%0b",
                                     $time, $signed(want.x), $signed(want.y), $signed(want.z),
                                     want.index, want.last);
                            $display("%0t:           got x=%0d y=%0d z=%0d idx=%0d last=%0b",
                                     $time, m_pos_x, m_pos_y, m_pos_z, m_sample_index, m_last);
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_mode == MODE_LOAD) begin
                    start_v = '{s_start_x, s_start_y, s_start_z};
                    end_v   = '{s_end_x, s_end_y, s_end_z};
                    for (k = 0; k < 3; k++) begin
                        move_origin[k] = start_v[k];
                        move_span[k]   = end_v[k] - start_v[k];
                    end
                    next_index = '0;
                    move_live  = 1'b1;
                end else if (move_live) begin
                    // a zero point count behaves as a single point
                    n   = (points_reg == 0) ? 1 : points_reg;
                    j   = next_index;
                    tau = (j >= n) ? longint'(ONE_Q) : (j << FRAC_BITS) / n;
                    p2  = (tau * tau) >> FRAC_BITS;
                    p3  = (p2 * tau) >> FRAC_BITS;
                    p4  = (p3 * tau) >> FRAC_BITS;
                    p5  = (p4 * tau) >> FRAC_BITS;
                    blend = 10 * longint'(p3) - 15 * longint'(p4) + 6 * longint'(p5);
                    if (blend < 0) begin
                        blend = 0;
                    end
                    if (blend > longint'(ONE_Q)) begin
                        blend = longint'(ONE_Q);
                    end
                    for (k = 0; k < 3; k++) begin
                        axis_pos[k] = POS_BITS'(move_origin[k] +
                                                ((move_span[k] * blend) >>> FRAC_BITS));
                    end
                    want.x     = axis_pos[0];
                    want.y     = axis_pos[1];
                    want.z     = axis_pos[2];
                    want.index = CNT_BITS'(j);
                    want.last  = (j + 1 >= n);
                    expected_samples = {expected_samples, want};
                    if (want.last) begin
                        move_live = 1'b0;
                    end
                    next_index = CNT_BITS'(j + 1);
                end
            end
        end
        pending <= expected_samples.size();
    end

endmodule

### sim/min_jerk_trajectory_generator_tb.sv
`timescale 1ns / 100ps

module min_jerk_trajectory_generator_tb;
    import mjt_pkg::*;

    localparam int   DRAIN_CYCLES = 64;
    localparam int   PHASE_ITEMS  = 56;
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam int   SEND_IDLE[4]  = '{0, 49, 0, 31};
    localparam int   RECV_STALL[4] = '{0, 0, 49, 31};
    localparam logic [CNT_BITS-1:0] PHASE_POINTS[8] =
        '{16'd3, 16'd7, 16'd1, 16'd20, 16'hFFFF, 16'd12, 16'd5, 16'd0};

    logic                       aclk;
    logic                       aresetn   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CNT_BITS-1:0]        cfg_data  = '0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic                       s_mode    = 1'b0;
    logic signed [POS_BITS-1:0] s_start_x = '0;
    logic signed [POS_BITS-1:0] s_start_y = '0;
    logic signed [POS_BITS-1:0] s_start_z = '0;
    logic signed [POS_BITS-1:0] s_end_x   = '0;
    logic signed [POS_BITS-1:0] s_end_y   = '0;
    logic signed [POS_BITS-1:0] s_end_z   = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic signed [POS_BITS-1:0] m_pos_x;
    logic signed [POS_BITS-1:0] m_pos_y;
    logic signed [POS_BITS-1:0] m_pos_z;
    logic [CNT_BITS-1:0]        m_sample_index;
    logic                       m_last;

    int mismatches;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    min_jerk_trajectory_generator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_start_z      (s_start_z),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .s_end_z        (s_end_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_pos_z        (m_pos_z),
        .m_sample_index (m_sample_index),
        .m_last         (m_last)
    );

    trajectory_checker traj_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_start_z      (s_start_z),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .s_end_z        (s_end_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_pos_z        (m_pos_z),
        .m_sample_index (m_sample_index),
        .m_last         (m_last),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic signed [POS_BITS-1:0] any_pos();
        case ($urandom_range(0, 7))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            default: return POS_BITS'($urandom);
        endcase
    endfunction

    task automatic send_item(logic mode, logic signed [POS_BITS-1:0] sx, sy, sz, ex, ey, ez);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_start_x <= sx;
        s_start_y <= sy;
        s_start_z <= sz;
        s_end_x   <= ex;
        s_end_y   <= ey;
        s_end_z   <= ez;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, any_pos(), any_pos(), any_pos(), any_pos(), any_pos(), any_pos());
    endtask

    task automatic send_random_load();
        send_item(MODE_LOAD, any_pos(), any_pos(), any_pos(), any_pos(), any_pos(), any_pos());
    endtask

    // wait for every sample to arrive, then let any dropped tick finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_points(logic [CNT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_moves(int budget, logic [CNT_BITS-1:0] pts);
        int sent;
        int ticks;
        int span;
        sent = 0;
        span = (pts == 0) ? 1 : pts;
        if (span > 40) begin
            span = 40;
        end
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), any_pos(), any_pos(), any_pos(),
                          any_pos(), any_pos(), any_pos());
                sent++;
            end else begin
                send_random_load();
                if ($urandom_range(0, 3) == 0) begin
                    ticks = $urandom_range(1, span);
                end else begin
                    ticks = span + $urandom_range(0, 1);
                end
                repeat (ticks) send_tick();
                sent += 1 + ((ticks > span) ? span : ticks);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset point count; tick with no move armed is dropped
        send_tick();
        send_item(MODE_LOAD, POS_MIN, POS_MAX, '0, POS_MAX, POS_MIN, '0);
        repeat (3) send_tick();
        settle();

        // count shrunk below the current index mid-move: saturates and ends
        set_points(CNT_BITS'(2));
        send_tick();
        send_tick();
        send_item(MODE_LOAD, '1, '1, '1, '0, '0, '0);
        repeat (2) send_tick();
        settle();

        set_points('0);
        send_random_load();
        send_tick();
        send_tick();
        settle();

        // reload while a move is still running
        set_points(16'hFFFF);
        send_item(MODE_LOAD, POS_MAX, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX);
        repeat (3) send_tick();
        send_random_load();
        repeat (2) send_tick();
        settle();

        for (int p = 0; p < 8; p++) begin
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            set_points(PHASE_POINTS[p]);
            run_moves(PHASE_ITEMS, PHASE_POINTS[p]);
            settle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
